>>> rtl/sobel_edge_magnitude_core_assert.svh
// Assertion macros for the Sobel edge magnitude core checker.
// Used by sem_checker.sv; expects i_clk and i_rst_n in scope.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define SEM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after a reset cycle.
`define SEM_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sem_pkg.sv
// Shared constants, types and codes for the Sobel edge magnitude core.
// No dependencies; imported by every RTL module and interface except sem_ram.
package sem_pkg;

    // Frame size limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W     = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W     = $clog2(MAX_WIDTH + 2);

    // Field widths
    localparam int PIXEL_W        = 8;
    localparam int MAG_W          = 8;
    localparam int CFG_WIDTH_BITS = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;

    // Reset values of the configuration registers
    localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Item modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Saturated magnitude
    localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

    // Root iteration count (one result bit per step)
    localparam int ROOT_BITS = MAG_W;
    localparam int RBIT_W    = $clog2(ROOT_BITS);

    // Controller to datapath commands
    typedef struct packed {
        logic              accept;
        logic              load;
        logic              square;
        logic              sum;
        logic              root;
        logic [RBIT_W-1:0] root_bit;
        logic              out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic emit;
        logic out_free;
    } t_status;

endpackage

>>> rtl/sem_in_if.sv
// Input stream interface: valid/ready handshake with mode and pixel.
// Depends on sem_pkg for field widths.
interface sem_in_if;
    import sem_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink   (input valid, input mode, input pixel, output ready);
endinterface

>>> rtl/sem_out_if.sv
// Result stream interface: valid/ready handshake with magnitude and flags.
// Depends on sem_pkg for field widths.
interface sem_out_if;
    import sem_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             line_end;
    logic             frame_end;

    modport source (output valid, output magnitude, output line_end, output frame_end,
                    input ready);
    modport sink   (input valid, input magnitude, input line_end, input frame_end,
                    output ready);
endinterface

>>> rtl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sem_ctrl.sv
// Controller FSM: load of one item, then square, sum, root and output if due.
// Depends on sem_pkg for the command and status structs.
module sem_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sem_pkg::t_status i_status,
    output sem_pkg::t_cmd    o_cmd
);
    import sem_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [RBIT_W-1:0] BIT_TOP = RBIT_W'(ROOT_BITS - 1);

    logic [2:0]        r_state, n_state;
    logic [RBIT_W-1:0] r_bit, n_bit;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.root_bit = r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_status.emit ? S_SQUARE : S_IDLE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_bit     = BIT_TOP;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end
endmodule

>>> rtl/sem_datapath.sv
// Datapath: config registers, counters, line stores, 3x3 window, gradient,
// bit-serial square root and output register. Depends on sem_pkg and sem_ram.
module sem_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  sem_pkg::t_cmd                  i_cmd,
    output sem_pkg::t_status               o_status,
    input  logic                           i_mode,
    input  logic [sem_pkg::PIXEL_W-1:0]    i_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sem_pkg::MAG_W-1:0]      o_magnitude,
    output logic                           o_line_end,
    output logic                           o_frame_end
);
    import sem_pkg::*;

    // Configuration registers
    logic [CFG_WIDTH_BITS-1:0]  r_cfg_w;
    logic [CFG_HEIGHT_BITS-1:0] r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RESET;
            r_cfg_h <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[CFG_WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[CFG_HEIGHT_BITS-1:0];
            endcase
        end
    end

    // Effective frame size, clamped to the legal range
    logic [WCNT_W-1:0] w_eff, w_last;
    logic [HCNT_W-1:0] h_eff, h_last;
    logic [PEND_W-1:0] w_plus1;

    always_comb begin
        if (r_cfg_w < 3) begin
            w_eff = WCNT_W'(3);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(r_cfg_w);
        end
        if (r_cfg_h < 3) begin
            h_eff = HCNT_W'(3);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = HCNT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HCNT_W'(r_cfg_h);
        end
    end

    assign w_last  = w_eff - 1'b1;
    assign h_last  = h_eff - 1'b1;
    assign w_plus1 = PEND_W'(w_eff) + 1'b1;

    // Position counters and backlog
    logic [COL_W-1:0]  r_in_col, r_out_col, in_col_cl, out_col_cl;
    logic [ROW_W-1:0]  r_in_row, r_out_row, in_row_cl, out_row_cl;
    logic [PEND_W-1:0] r_pend, pend_cl;
    logic              r_mode;
    logic [PIXEL_W-1:0] r_pixel;

    // Counters found beyond the current size restart at zero
    assign in_col_cl  = (WCNT_W'(r_in_col) >= w_eff) ? '0 : r_in_col;
    assign out_col_cl = (WCNT_W'(r_out_col) >= w_eff) ? '0 : r_out_col;
    assign in_row_cl  = (HCNT_W'(r_in_row) >= h_eff) ? '0 : r_in_row;
    assign out_row_cl = (HCNT_W'(r_out_row) >= h_eff) ? '0 : r_out_row;
    assign pend_cl    = (r_pend > w_plus1) ? w_plus1 : r_pend;

    logic in_col_last, in_row_last, out_col_last, out_row_last, emit;

    assign in_col_last  = (WCNT_W'(r_in_col) == w_last);
    assign in_row_last  = (HCNT_W'(r_in_row) == h_last);
    assign out_col_last = (WCNT_W'(r_out_col) == w_last);
    assign out_row_last = (HCNT_W'(r_out_row) == h_last);

    // Result due: full backlog on a pixel, any backlog on a drain tick
    assign emit = (r_mode == MODE_PIXEL) ? (r_pend >= w_plus1) : (r_pend != '0);

    // Line stores
    logic [PIXEL_W-1:0] upper_rd, middle_rd;
    logic               store_we;

    assign store_we = i_cmd.load && (r_mode == MODE_PIXEL);

    sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_in_col),
        .i_wdata (middle_rd),
        .i_re    (i_cmd.accept),
        .i_raddr (in_col_cl),
        .o_rdata (upper_rd)
    );

    sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_in_col),
        .i_wdata (r_pixel),
        .i_re    (i_cmd.accept),
        .i_raddr (in_col_cl),
        .o_rdata (middle_rd)
    );

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode  <= i_mode;
            r_pixel <= i_pixel;
        end
    end

    // Counters, backlog and window
    logic [PIXEL_W-1:0] r_win [9];
    logic               r_border, r_le, r_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_in_col  <= in_col_cl;
            r_in_row  <= in_row_cl;
            r_out_col <= out_col_cl;
            r_out_row <= out_row_cl;
            r_pend    <= pend_cl;
        end else if (i_cmd.load) begin
            if (r_mode == MODE_PIXEL) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3]   <= r_win[r*3+1];
                    r_win[r*3+1] <= r_win[r*3+2];
                end
                r_win[2] <= upper_rd;
                r_win[5] <= middle_rd;
                r_win[8] <= r_pixel;
                if (in_col_last) begin
                    r_in_col <= '0;
                    r_in_row <= in_row_last ? '0 : r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
                if (!emit) begin
                    r_pend <= r_pend + 1'b1;
                end
            end else if (emit) begin
                r_pend <= r_pend - 1'b1;
            end
            if (emit) begin
                if (out_col_last) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_last ? '0 : r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // Position flags of the result being produced
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && emit) begin
            r_border <= (r_out_row == '0) || out_row_last || (r_out_col == '0) || out_col_last;
            r_le     <= out_col_last;
            r_fe     <= out_col_last && out_row_last;
        end
    end

    // Gradients and squares
    logic signed [10:0] gx, gy;
    logic signed [21:0] prod_x, prod_y;
    logic [19:0]        r_sqx, r_sqy;

    assign gx = signed'({3'b0, r_win[2]} + {2'b0, r_win[5], 1'b0} + {3'b0, r_win[8]})
              - signed'({3'b0, r_win[0]} + {2'b0, r_win[3], 1'b0} + {3'b0, r_win[6]});
    assign gy = signed'({3'b0, r_win[6]} + {2'b0, r_win[7], 1'b0} + {3'b0, r_win[8]})
              - signed'({3'b0, r_win[0]} + {2'b0, r_win[1], 1'b0} + {3'b0, r_win[2]});
    assign prod_x = gx * gx;
    assign prod_y = gy * gy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sqx <= prod_x[19:0];
            r_sqy <= prod_y[19:0];
        end
    end

    // Sum of squares, saturation and restoring square root (one bit per step)
    logic [20:0]      sum_sq;
    logic [15:0]      r_rad;
    logic             r_sat;
    logic [MAG_W-1:0] r_root, trial;
    logic [15:0]      trial_sq;

    assign sum_sq   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign trial    = r_root | (MAG_W'(1) << i_cmd.root_bit);
    assign trial_sq = trial * trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sat  <= |sum_sq[20:16];
            r_rad  <= sum_sq[15:0];
            r_root <= '0;
        end else if (i_cmd.root) begin
            if (trial_sq <= r_rad) begin
                r_root <= trial;
            end
        end
    end

    // Output register
    logic             r_out_valid;
    logic [MAG_W-1:0] r_mag;
    logic             r_out_le, r_out_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mag    <= r_border ? '0 : (r_sat ? MAG_MAX : r_root);
            r_out_le <= r_le;
            r_out_fe <= r_fe;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_magnitude       = r_mag;
    assign o_line_end        = r_out_le;
    assign o_frame_end       = r_out_fe;
    assign o_status.emit     = emit;
    assign o_status.out_free = !r_out_valid || i_out_ready;
endmodule

>>> rtl/sobel_edge_magnitude_core.sv
// Sobel edge magnitude core: streaming 3x3 Sobel gradient magnitude on grey pixels.
// Pixels enter on i_pix in raster order (mode 0); drain ticks (mode 1) after the
// frame push out pending results. Results leave on o_res with line_end/frame_end.
// Frame size comes from the write port (index 0 width, index 1 height); the user
// writes it only while the core is idle (not enforced); out-of-range sizes are clamped.
// Latency: a pixel's result appears one row plus one pixel later in the stream;
// no result comes out until width+1 pixels are pending, border pixels give zero.
// Throughput: one item at a time. A pixel or drain tick that gives no result
// passes only the load state; one that gives a result goes from transfer to the
// output register through load, square, sum, 8 root steps and output.
// i_pix.ready is high only between items.
// A finished result waits in the output register while o_res is stalled; the
// next item is still taken and runs until it needs that register.
// Reset (synchronous, active low) clears counters, window, backlog and output
// valid and restores 640x480. Line stores need no clearing: an entry is always
// written before any result depends on it.
// Depends on sem_pkg, sem_in_if, sem_out_if, sem_ctrl, sem_datapath, sem_ram.
module sobel_edge_magnitude_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sem_in_if.sink                         i_pix,
    sem_out_if.source                      o_res
);
    import sem_pkg::*;

    t_cmd    cmd;
    t_status status;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sem_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_mode      (i_pix.mode),
        .i_pixel     (i_pix.pixel),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_magnitude (o_res.magnitude),
        .o_line_end  (o_res.line_end),
        .o_frame_end (o_res.frame_end)
    );
endmodule

>>> rtl/sem_checker.sv
// Port-level checker for the Sobel edge magnitude core, bound to the top level.
// Depends on sem_pkg and sobel_edge_magnitude_core_assert.svh.
`include "sobel_edge_magnitude_core_assert.svh"

module sem_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [sem_pkg::MAG_W-1:0]   i_magnitude,
    input logic                        i_line_end,
    input logic                        i_frame_end
);
    import sem_pkg::*;

    // Stalled result holds
    `SEM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_magnitude) && $stable(i_line_end) && $stable(i_frame_end), "result changed while stalled")

    // Nothing to show right after reset
    `SEM_ASSERT_RESET(a_reset_idle, !i_out_valid, "result valid after reset")

    // One item in flight: no transfer in the cycle after a transfer
    `SEM_ASSERT_NEXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready, "input ready right after a transfer")

    // Last column is border: zero magnitude; frame end is also a row end
    `SEM_ASSERT_SAME(a_row_end_zero, i_out_valid && i_line_end, i_magnitude == '0, "nonzero magnitude at row end")
    `SEM_ASSERT_SAME(a_frame_row, i_out_valid && i_frame_end, i_line_end, "frame end without row end")
endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_magnitude (o_res.magnitude),
    .i_line_end  (o_res.line_end),
    .i_frame_end (o_res.frame_end)
);
